// ===== rtl/core/cbsf_pkg.sv =====
package cbsf_pkg;

    localparam logic [2:0] KIND_WR_INS = 3'd0;
    localparam logic [2:0] KIND_ATTACH = 3'd1;
    localparam logic [2:0] KIND_WR_DATA = 3'd2;
    localparam logic [2:0] KIND_EVAL = 3'd3;
    localparam logic [2:0] KIND_CLEAR = 3'd4;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_REJECT = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    localparam logic [2:0] CLS_LD = 3'h0;
    localparam logic [2:0] CLS_LDX = 3'h1;
    localparam logic [2:0] CLS_ALU = 3'h4;
    localparam logic [2:0] CLS_JMP = 3'h5;
    localparam logic [2:0] CLS_RET = 3'h6;
    localparam logic [2:0] CLS_MISC = 3'h7;

    localparam logic [2:0] MODE_IMM = 3'h0;
    localparam logic [2:0] MODE_ABS = 3'h1;
    localparam logic [2:0] MODE_MEM = 3'h3;

    localparam logic [3:0] ALU_ADD = 4'h0;
    localparam logic [3:0] ALU_SUB = 4'h1;
    localparam logic [3:0] ALU_MUL = 4'h2;
    localparam logic [3:0] ALU_DIV = 4'h3;
    localparam logic [3:0] ALU_OR = 4'h4;
    localparam logic [3:0] ALU_AND = 4'h5;
    localparam logic [3:0] ALU_LSH = 4'h6;
    localparam logic [3:0] ALU_RSH = 4'h7;
    localparam logic [3:0] ALU_NEG = 4'h8;
    localparam logic [3:0] ALU_MOD = 4'h9;
    localparam logic [3:0] ALU_XOR = 4'ha;

    localparam logic [3:0] JMP_JA = 4'h0;
    localparam logic [3:0] JMP_JEQ = 4'h1;
    localparam logic [3:0] JMP_JGT = 4'h2;
    localparam logic [3:0] JMP_JGE = 4'h3;
    localparam logic [3:0] JMP_JSET = 4'h4;

    localparam logic [1:0] RVAL_K = 2'b00;
    localparam logic [1:0] RVAL_A = 2'b10;

    localparam logic [4:0] MISC_TAX = 5'h00;
    localparam logic [4:0] MISC_TXA = 5'h10;

    localparam logic [31:0] RET_KILL_PROCESS = 32'h8000_0000;
    localparam logic [31:0] RET_ALLOW = 32'h7fff_0000;

    localparam int DATA_WORDS = 16;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_VAL_RD,
        S_VAL_CHK,
        S_RUN_RD,
        S_RUN_EX,
        S_RUN_DIV,
        S_FIN
    } t_state;

    typedef struct packed {
        logic latch;
        logic dispatch;
        logic rd;
        logic chk;
        logic exec;
        logic div_step;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic [2:0] kind;
        logic       full;
        logic       bad_len;
        logic       empty;
        logic       chk_err;
        logic       pc_last;
        logic       need_div;
        logic       term;
        logic       more;
        logic       div_done;
        logic       out_free;
    } t_sts;

    function automatic logic [2:0] action_rank(input logic [31:0] v);
        logic [2:0] r;
        unique case (v[31:16])
            16'h8000: r = 3'd0;
            16'h0000: r = 3'd1;
            16'h0003: r = 3'd2;
            16'h0005: r = 3'd3;
            16'h7ff0: r = 3'd4;
            16'h7ffc: r = 3'd5;
            16'h7fff: r = 3'd6;
            default:  r = 3'd0;
        endcase
        return r;
    endfunction

endpackage

// ===== rtl/core/cbsf_ctrl.sv =====
module cbsf_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  cbsf_pkg::t_sts  i_sts,
    output cbsf_pkg::t_cmd  o_cmd
);
    import cbsf_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd = '0;
        o_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                o_cmd.dispatch = 1'b1;
                if (i_sts.kind == KIND_ATTACH && !i_sts.full && !i_sts.bad_len) begin
                    n_state = S_VAL_RD;
                end else if (i_sts.kind == KIND_EVAL && !i_sts.empty) begin
                    n_state = S_RUN_RD;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_VAL_RD: begin
                o_cmd.rd = 1'b1;
                n_state = S_VAL_CHK;
            end
            S_VAL_CHK: begin
                o_cmd.chk = 1'b1;
                n_state = (i_sts.chk_err || i_sts.pc_last) ? S_FIN : S_VAL_RD;
            end
            S_RUN_RD: begin
                o_cmd.rd = 1'b1;
                n_state = S_RUN_EX;
            end
            S_RUN_EX: begin
                o_cmd.exec = 1'b1;
                if (i_sts.need_div) begin
                    n_state = S_RUN_DIV;
                end else if (i_sts.term && !i_sts.more) begin
                    n_state = S_FIN;
                end else begin
                    n_state = S_RUN_RD;
                end
            end
            S_RUN_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_done) begin
                    n_state = S_RUN_RD;
                end
            end
            S_FIN: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

// ===== rtl/core/cbsf_datapath.sv =====
module cbsf_datapath #(
    parameter int MAX_PROGRAM_LEN = 4096,
    parameter int MAX_FILTERS = 4
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  cbsf_pkg::t_cmd  i_cmd,
    output cbsf_pkg::t_sts  o_sts,
    input  logic [2:0]      i_kind,
    input  logic [11:0]     i_index,
    input  logic [15:0]     i_opcode_word,
    input  logic [7:0]      i_jump_true,
    input  logic [7:0]      i_jump_false,
    input  logic [31:0]     i_immediate,
    input  logic [31:0]     i_data_word,
    input  logic [12:0]     i_prog_length,
    output logic            o_valid,
    input  logic            i_ready,
    output logic [1:0]      o_status,
    output logic [31:0]     o_action
);
    import cbsf_pkg::*;

    localparam int PW = $clog2(MAX_PROGRAM_LEN);
    localparam int LW = $clog2(MAX_PROGRAM_LEN + 1);
    localparam int SW = (MAX_FILTERS > 1) ? $clog2(MAX_FILTERS) : 1;
    localparam int CW = $clog2(MAX_FILTERS + 1);
    localparam int DEPTH = MAX_FILTERS * MAX_PROGRAM_LEN;
    localparam int AW = $clog2(DEPTH);

    logic [2:0]  r_kind;
    logic [11:0] r_index;
    logic [63:0] r_ins;
    logic [31:0] r_dword;
    logic [12:0] r_plen;

    logic [63:0] r_mem [DEPTH];
    logic [63:0] r_rdata;

    logic [LW-1:0] r_len [MAX_FILTERS];
    logic [CW-1:0] r_count;
    logic [31:0]   r_words [DATA_WORDS];

    logic [PW-1:0] r_pc;
    logic [31:0]   r_a;
    logic [31:0]   r_x;
    logic [SW-1:0] r_slot;
    logic [1:0]    r_status;
    logic [31:0]   r_action;

    logic [31:0] r_dq;
    logic [31:0] r_drem;
    logic [31:0] r_dd;
    logic [4:0]  r_dcnt;
    logic        r_dmod;

    logic        r_out_valid;
    logic [1:0]  r_out_status;
    logic [31:0] r_out_action;

    logic          full;
    logic          idx_ok;
    logic          bad_len;
    logic          is_eval;
    logic [SW-1:0] pend_slot;
    logic [SW-1:0] rd_slot;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_addr;
    logic          mem_we;
    logic [LW-1:0] cur_len;

    logic [15:0] code;
    logic [2:0]  cls;
    logic [2:0]  mode;
    logic [3:0]  op;
    logic [7:0]  jt;
    logic [7:0]  jf;
    logic [31:0] k;
    logic [31:0] opnd;
    logic [33:0] t_k;
    logic [33:0] t_jt;
    logic [33:0] t_jf;
    logic [33:0] len_w;
    logic        pc_last;
    logic        bad;
    logic        chk_err;

    logic [31:0] ex_a;
    logic [31:0] ex_x;
    logic [33:0] ex_nxt;
    logic        ex_term;
    logic [31:0] ex_ret;
    logic        need_div;
    logic        taken;
    logic        fold_win;

    logic [32:0] d_sh;
    logic        d_ge;
    logic [31:0] d_rem;
    logic [31:0] d_q;
    logic        out_free;

    assign full = (r_count == CW'(MAX_FILTERS));
    assign idx_ok = ({1'b0, r_index} < 13'(MAX_PROGRAM_LEN));
    assign bad_len = (r_plen == 13'd0) || (r_plen > 13'(MAX_PROGRAM_LEN));
    assign is_eval = (r_kind == KIND_EVAL);
    assign pend_slot = SW'(r_count);
    assign rd_slot = is_eval ? r_slot : pend_slot;
    assign wr_addr = AW'(pend_slot) * AW'(MAX_PROGRAM_LEN) + AW'(r_index[PW-1:0]);
    assign rd_addr = AW'(rd_slot) * AW'(MAX_PROGRAM_LEN) + AW'(r_pc);
    assign mem_we = i_cmd.dispatch && (r_kind == KIND_WR_INS) && !full && idx_ok;
    assign cur_len = is_eval ? r_len[r_slot] : LW'(r_plen);

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[wr_addr] <= r_ins;
        end
        if (i_cmd.rd) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

    assign code = r_rdata[15:0];
    assign cls = code[2:0];
    assign mode = code[7:5];
    assign op = code[7:4];
    assign jt = r_rdata[23:16];
    assign jf = r_rdata[31:24];
    assign k = r_rdata[63:32];
    assign opnd = code[3] ? r_x : k;
    assign t_k = 34'(r_pc) + 34'd1 + 34'(k);
    assign t_jt = 34'(r_pc) + 34'd1 + 34'(jt);
    assign t_jf = 34'(r_pc) + 34'd1 + 34'(jf);
    assign len_w = 34'(cur_len);
    assign pc_last = ((34'(r_pc) + 34'd1) == len_w);

    always_comb begin
        bad = 1'b0;
        case (cls)
            CLS_LD: begin
                if (mode == MODE_ABS) begin
                    bad = (k >= 32'd64) || (k[1:0] != 2'b00);
                end else if (mode == MODE_MEM) begin
                    bad = (k >= 32'd16);
                end else begin
                    bad = (mode != MODE_IMM);
                end
            end
            CLS_LDX: begin
                if (mode == MODE_MEM) begin
                    bad = (k >= 32'd16);
                end else begin
                    bad = (mode != MODE_IMM);
                end
            end
            CLS_ALU: bad = (op > ALU_XOR);
            CLS_JMP: begin
                if (op == JMP_JA) begin
                    bad = (t_k >= len_w);
                end else if (op <= JMP_JSET) begin
                    bad = (t_jt >= len_w) || (t_jf >= len_w);
                end else begin
                    bad = 1'b1;
                end
            end
            CLS_RET: bad = (code[4:3] != RVAL_K) && (code[4:3] != RVAL_A);
            CLS_MISC: bad = (code[7:3] != MISC_TAX) && (code[7:3] != MISC_TXA);
            default: bad = 1'b1;
        endcase
    end

    assign chk_err = bad || (pc_last && (cls != CLS_RET));

    always_comb begin
        ex_a = r_a;
        ex_x = r_x;
        ex_nxt = 34'(r_pc) + 34'd1;
        ex_term = 1'b0;
        ex_ret = RET_KILL_PROCESS;
        need_div = 1'b0;
        taken = 1'b0;
        case (cls)
            CLS_LD: begin
                if (mode == MODE_ABS) begin
                    ex_a = r_words[k[5:2]];
                end else if (mode == MODE_IMM) begin
                    ex_a = k;
                end else begin
                    ex_a = '0;
                end
            end
            CLS_LDX: ex_x = (mode == MODE_IMM) ? k : '0;
            CLS_ALU: begin
                case (op)
                    ALU_ADD: ex_a = r_a + opnd;
                    ALU_SUB: ex_a = r_a - opnd;
                    ALU_MUL: ex_a = r_a * opnd;
                    ALU_DIV, ALU_MOD: begin
                        if (opnd == '0) begin
                            ex_a = '0;
                        end else begin
                            need_div = 1'b1;
                        end
                    end
                    ALU_OR:  ex_a = r_a | opnd;
                    ALU_AND: ex_a = r_a & opnd;
                    ALU_LSH: ex_a = r_a << opnd[4:0];
                    ALU_RSH: ex_a = r_a >> opnd[4:0];
                    ALU_NEG: ex_a = 32'd0 - r_a;
                    ALU_XOR: ex_a = r_a ^ opnd;
                    default: ex_a = r_a;
                endcase
            end
            CLS_JMP: begin
                case (op)
                    JMP_JEQ:  taken = (r_a == opnd);
                    JMP_JGT:  taken = (r_a > opnd);
                    JMP_JGE:  taken = (r_a >= opnd);
                    JMP_JSET: taken = ((r_a & opnd) != '0);
                    default:  taken = 1'b0;
                endcase
                if (op == JMP_JA) begin
                    ex_nxt = t_k;
                end else begin
                    ex_nxt = taken ? t_jt : t_jf;
                end
            end
            CLS_RET: begin
                ex_term = 1'b1;
                ex_ret = (code[4:3] == RVAL_A) ? r_a : k;
            end
            CLS_MISC: begin
                if (code[7:3] == MISC_TAX) begin
                    ex_x = r_a;
                end else begin
                    ex_a = r_x;
                end
            end
            default: ex_term = 1'b1;
        endcase
        if (!ex_term && !need_div && (ex_nxt >= len_w)) begin
            ex_term = 1'b1;
            ex_ret = RET_KILL_PROCESS;
        end
    end

    assign fold_win = (action_rank(ex_ret) < action_rank(r_action));

    assign d_sh = {r_drem, r_dq[31]};
    assign d_ge = (d_sh >= {1'b0, r_dd});
    assign d_rem = d_ge ? 32'(d_sh - {1'b0, r_dd}) : d_sh[31:0];
    assign d_q = {r_dq[30:0], d_ge};

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_kind <= i_kind;
            r_index <= i_index;
            r_ins <= {i_immediate, i_jump_false, i_jump_true, i_opcode_word};
            r_dword <= i_data_word;
            r_plen <= i_prog_length;
        end
        if (i_cmd.dispatch) begin
            r_status <= ST_OK;
            r_action <= is_eval ? RET_ALLOW : '0;
            r_pc <= '0;
            r_a <= '0;
            r_x <= '0;
            r_slot <= SW'(r_count - CW'(1));
            if (r_kind == KIND_ATTACH) begin
                if (full) begin
                    r_status <= ST_FULL;
                end else if (bad_len) begin
                    r_status <= ST_REJECT;
                end
            end
        end
        if (i_cmd.chk) begin
            if (chk_err) begin
                r_status <= ST_REJECT;
            end else if (!pc_last) begin
                r_pc <= r_pc + PW'(1);
            end
        end
        if (i_cmd.exec) begin
            if (need_div) begin
                r_dq <= r_a;
                r_drem <= '0;
                r_dd <= opnd;
                r_dcnt <= '0;
                r_dmod <= (op == ALU_MOD);
            end else if (ex_term) begin
                if (fold_win) begin
                    r_action <= ex_ret;
                end
                r_slot <= r_slot - SW'(1);
                r_pc <= '0;
                r_a <= '0;
                r_x <= '0;
            end else begin
                r_a <= ex_a;
                r_x <= ex_x;
                r_pc <= ex_nxt[PW-1:0];
            end
        end
        if (i_cmd.div_step) begin
            r_dq <= d_q;
            r_drem <= d_rem;
            r_dcnt <= r_dcnt + 5'd1;
            if (r_dcnt == 5'd31) begin
                r_a <= r_dmod ? d_rem : d_q;
                r_pc <= r_pc + PW'(1);
            end
        end
        if (i_cmd.out_load) begin
            r_out_status <= r_status;
            r_out_action <= r_action;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            for (int i = 0; i < MAX_FILTERS; i++) begin
                r_len[i] <= '0;
            end
            for (int i = 0; i < DATA_WORDS; i++) begin
                r_words[i] <= '0;
            end
        end else begin
            if (i_cmd.dispatch && (r_kind == KIND_WR_DATA) && (r_index < 12'(DATA_WORDS))) begin
                r_words[r_index[3:0]] <= r_dword;
            end
            if (i_cmd.dispatch && (r_kind == KIND_CLEAR)) begin
                r_count <= '0;
                for (int i = 0; i < MAX_FILTERS; i++) begin
                    r_len[i] <= '0;
                end
            end
            if (i_cmd.chk && !chk_err && pc_last) begin
                r_len[pend_slot] <= LW'(r_plen);
                r_count <= r_count + CW'(1);
            end
        end
    end

    assign out_free = !r_out_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_valid = r_out_valid;
    assign o_status = r_out_status;
    assign o_action = r_out_action;

    always_comb begin
        o_sts.kind = r_kind;
        o_sts.full = full;
        o_sts.bad_len = bad_len;
        o_sts.empty = (r_count == '0);
        o_sts.chk_err = chk_err;
        o_sts.pc_last = pc_last;
        o_sts.need_div = need_div;
        o_sts.term = ex_term;
        o_sts.more = (r_slot != '0);
        o_sts.div_done = (r_dcnt == 5'd31);
        o_sts.out_free = out_free;
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_FILTERS))
        else $error("filter count above capacity");
    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.dispatch && r_kind == KIND_CLEAR) |=> (r_count == '0))
        else $error("clear left filters attached");
    a_out_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> (!r_out_valid || i_ready))
        else $error("result overwritten before transaction");
    a_div_init: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.exec && need_div) |=> (r_dcnt == '0 && i_cmd.div_step))
        else $error("divider not started");
`endif

endmodule

// ===== rtl/core/classic_bpf_syscall_filter_engine_top.sv =====
// Classic-BPF syscall filter engine: holds up to MAX_FILTERS programs in one
// instruction memory with a registered read, so every instruction takes a
// read step, then a check or execute step. Each item passes through accept,
// dispatch and result load; write-instruction, data-word, clear and unused
// kinds do nothing more. Attach checks each instruction in turn and stops at
// the first bad one; a bad length or a full chain ends it with no check.
// Evaluate executes every instruction reached over all attached filters, and
// each division or modulo with a nonzero divisor runs on a bit-serial
// divider. The next transaction is accepted while a result waits in the
// output register; its own result then holds until that register frees. No
// clearing pass follows reset.
module classic_bpf_syscall_filter_engine_top #(
    parameter int MAX_PROGRAM_LEN = 4096,
    parameter int MAX_FILTERS = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [2:0]  i_kind,
    input  logic [11:0] i_index,
    input  logic [15:0] i_opcode_word,
    input  logic [7:0]  i_jump_true,
    input  logic [7:0]  i_jump_false,
    input  logic [31:0] i_immediate,
    input  logic [31:0] i_data_word,
    input  logic [12:0] i_prog_length,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_status,
    output logic [31:0] o_action
);
    import cbsf_pkg::*;

    t_cmd cmd;
    t_sts sts;

    cbsf_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    cbsf_datapath #(
        .MAX_PROGRAM_LEN (MAX_PROGRAM_LEN),
        .MAX_FILTERS     (MAX_FILTERS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_kind        (i_kind),
        .i_index       (i_index),
        .i_opcode_word (i_opcode_word),
        .i_jump_true   (i_jump_true),
        .i_jump_false  (i_jump_false),
        .i_immediate   (i_immediate),
        .i_data_word   (i_data_word),
        .i_prog_length (i_prog_length),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_status      (o_status),
        .o_action      (o_action)
    );

endmodule
